### hdl/rtph_pkg.sv
// Shared constants and types for the RTP fixed-header parser.
// Used by rtph_capture, rtph_eval and rtp_header_parser; no dependencies.
package rtph_pkg;

  // Width of the packet byte counter. The counter saturates at all ones.
  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Fixed header is 12 bytes; 12 + 4*CC needs 7 bits.
  localparam int HL_W = 7;
  localparam logic [HL_W-1:0] HDR_FIXED = 7'd12;

  // Full header: 12 + 60 + 4 + 4*65535 fits in 19 bits.
  localparam int HDR_W  = 19;
  // Signed difference of byte count and header (plus pad byte).
  localparam int DIFF_W = HDR_W + 1;
  localparam int LEN_W  = 16;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDER_12  = 3'd1;
  localparam logic [2:0] ST_NO_EXT    = 3'd2;
  localparam logic [2:0] ST_SHORT_HDR = 3'd3;
  localparam logic [2:0] ST_BAD_PAD   = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  // Packet state frozen on the last byte
  typedef struct packed {
    logic [7:0]       flags;
    logic [7:0]       mtype;
    logic [15:0]      seq;
    logic [31:0]      stamp;
    logic [31:0]      source;
    logic [15:0]      ext;
    logic [CNT_W-1:0] size;
    logic             ovf;
    logic [7:0]       pad_byte;
  } snap_t;

  // Result beat, first member in the highest bits (status lands at bit 0)
  typedef struct packed {
    logic [LEN_W-1:0] payload_length;
    logic [LEN_W-1:0] payload_offset;
    logic [31:0]      source_id;
    logic [31:0]      time_stamp;
    logic [15:0]      sequence_res;
    logic [6:0]       payload_type;
    logic             marker;
    logic [3:0]       csrc_count;
    logic             has_extension;
    logic             has_padding;
    logic [1:0]       version;
    logic [2:0]       status;
  } res_t;

  localparam int RES_W = $bits(res_t);
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

endpackage

### hdl/rtph_capture.sv
// Byte capture for the RTP parser: counts bytes, latches the header words
// and freezes them into a snapshot on the last byte. Depends on rtph_pkg.
module rtph_capture (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tlast,
  output logic           snap_valid,
  input  logic           snap_ready,
  output rtph_pkg::snap_t snap
);
  import rtph_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [7:0]       mtype_r, mtype_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [31:0]      stamp_r, stamp_nxt;
  logic [31:0]      source_r, source_nxt;
  logic [15:0]      ext_r, ext_nxt;
  logic             ovf_r, ovf_nxt;
  logic             snap_v_r;
  snap_t            snap_r;
  logic [HL_W-1:0]  hl;
  logic             take;

  assign take      = in_tvalid && in_tready;
  assign in_tready = !snap_v_r || snap_ready;
  assign hl        = HDR_FIXED + {1'b0, flags_r[3:0], 2'b00};

  always_comb begin
    count_nxt  = count_r;
    flags_nxt  = flags_r;
    mtype_nxt  = mtype_r;
    seq_nxt    = seq_r;
    stamp_nxt  = stamp_r;
    source_nxt = source_r;
    ext_nxt    = ext_r;
    ovf_nxt    = ovf_r;

    if (count_r == '0) begin
      flags_nxt = in_tdata;
    end else if (count_r == CNT_W'(1)) begin
      mtype_nxt = in_tdata;
    end else if (count_r < CNT_W'(4)) begin
      seq_nxt = {seq_r[7:0], in_tdata};
    end else if (count_r < CNT_W'(8)) begin
      stamp_nxt = {stamp_r[23:0], in_tdata};
    end else if (count_r < CNT_W'(12)) begin
      source_nxt = {source_r[23:0], in_tdata};
    end else if (count_r == CNT_W'(hl + 7'd2) || count_r == CNT_W'(hl + 7'd3)) begin
      // extension length word sits after the CSRC list and profile field
      ext_nxt = {ext_r[7:0], in_tdata};
    end

    if (count_r == CNT_MAX) begin
      ovf_nxt = 1'b1;
    end else begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      flags_r  <= '0;
      mtype_r  <= '0;
      seq_r    <= '0;
      stamp_r  <= '0;
      source_r <= '0;
      ext_r    <= '0;
      ovf_r    <= 1'b0;
      snap_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        snap_v_r <= take && in_tlast;
      end
      if (take) begin
        if (in_tlast) begin
          count_r  <= '0;
          flags_r  <= '0;
          mtype_r  <= '0;
          seq_r    <= '0;
          stamp_r  <= '0;
          source_r <= '0;
          ext_r    <= '0;
          ovf_r    <= 1'b0;
        end else begin
          count_r  <= count_nxt;
          flags_r  <= flags_nxt;
          mtype_r  <= mtype_nxt;
          seq_r    <= seq_nxt;
          stamp_r  <= stamp_nxt;
          source_r <= source_nxt;
          ext_r    <= ext_nxt;
          ovf_r    <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_tlast) begin
      snap_r.flags    <= flags_nxt;
      snap_r.mtype    <= mtype_nxt;
      snap_r.seq      <= seq_nxt;
      snap_r.stamp    <= stamp_nxt;
      snap_r.source   <= source_nxt;
      snap_r.ext      <= ext_nxt;
      snap_r.size     <= count_nxt;
      snap_r.ovf      <= ovf_nxt;
      snap_r.pad_byte <= in_tdata;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_tlast |=> count_r == '0 && snap_v_r)
    else $error("capture state not cleared after last beat");

  a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_MAX)
    else $error("overflow flag set below saturated count");

  a_snap_ovf_size: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && snap_r.ovf |-> snap_r.size == CNT_MAX)
    else $error("overflowed snapshot without saturated size");

endmodule

### hdl/rtph_eval.sv
// Header length and status evaluation for the RTP parser: two register
// stages from packet snapshot to result beat. Depends on rtph_pkg.
module rtph_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       snap_valid,
  output logic                       snap_ready,
  input  rtph_pkg::snap_t            snap,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rtph_pkg::OUT_W-1:0] out_tdata
);
  import rtph_pkg::*;

  // stage 2: header length and early status
  logic             s2_v_r;
  snap_t            s2_snap_r;
  logic [HDR_W-1:0] s2_hdr_r;
  logic             s2_fail_r;
  logic [2:0]       s2_st_r;

  logic [HL_W-1:0]  hdr_base;
  logic [HDR_W-1:0] ext_len;
  logic [HDR_W-1:0] hdr_full;
  logic             pre_fail;
  logic [2:0]       pre_st;

  // output stage
  logic             out_v_r;
  res_t             out_res_r;
  res_t             res;
  logic [DIFF_W-1:0] d_raw;
  logic [DIFF_W-1:0] d_pad;
  logic             short_hdr;
  logic             pad_cut;
  logic             bad_pad;
  logic [2:0]       st;

  logic out_adv;
  logic s2_adv;

  assign out_adv    = !out_v_r || out_tready;
  assign s2_adv     = !s2_v_r || out_adv;
  assign snap_ready = s2_adv;

  always_comb begin
    hdr_base = HDR_FIXED + {1'b0, snap.flags[3:0], 2'b00};
    ext_len  = HDR_W'({snap.ext, 2'b00}) + HDR_W'(4);
    hdr_full = HDR_W'(hdr_base) + (snap.flags[4] ? ext_len : '0);

    pre_fail = 1'b1;
    if (snap.ovf) begin
      pre_st = ST_TOO_LONG;
    end else if (snap.size < CNT_W'(HDR_FIXED)) begin
      pre_st = ST_UNDER_12;
    end else if (snap.flags[4] && snap.size < CNT_W'(hdr_base + 7'd4)) begin
      pre_st = ST_NO_EXT;
    end else begin
      pre_st   = ST_OK;
      pre_fail = 1'b0;
    end
  end

  always_comb begin
    d_raw     = DIFF_W'(s2_snap_r.size) - DIFF_W'(s2_hdr_r);
    d_pad     = DIFF_W'(s2_snap_r.size) - DIFF_W'(s2_hdr_r) - DIFF_W'(s2_snap_r.pad_byte);
    short_hdr = d_raw[DIFF_W-1];
    // padding only trimmed from a non-empty payload
    pad_cut   = s2_snap_r.flags[5] && !short_hdr && d_raw != '0;
    bad_pad   = pad_cut && d_pad[DIFF_W-1];

    if (s2_fail_r) begin
      st = s2_st_r;
    end else if (short_hdr) begin
      st = ST_SHORT_HDR;
    end else if (bad_pad) begin
      st = ST_BAD_PAD;
    end else begin
      st = ST_OK;
    end

    res.status        = st;
    res.version       = s2_snap_r.flags[7:6];
    res.has_padding   = s2_snap_r.flags[5];
    res.has_extension = s2_snap_r.flags[4];
    res.csrc_count    = s2_snap_r.flags[3:0];
    res.marker        = s2_snap_r.mtype[7];
    res.payload_type  = s2_snap_r.mtype[6:0];
    res.sequence_res  = s2_snap_r.seq;
    res.time_stamp    = s2_snap_r.stamp;
    res.source_id     = s2_snap_r.source;
    if (st == ST_OK) begin
      res.payload_offset = s2_hdr_r[LEN_W-1:0];
      res.payload_length = pad_cut ? d_pad[LEN_W-1:0] : d_raw[LEN_W-1:0];
    end else begin
      res.payload_offset = '0;
      res.payload_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_v_r <= snap_valid;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && snap_valid) begin
      s2_snap_r <= snap;
      s2_hdr_r  <= hdr_full;
      s2_fail_r <= pre_fail;
      s2_st_r   <= pre_st;
    end
    if (out_adv && s2_v_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W - RES_W){1'b0}}, out_res_r};

  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.status == ST_OK |-> out_res_r.payload_offset >= 16'd12)
    else $error("ok result with offset inside fixed header");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.status != ST_OK
      |-> out_res_r.payload_offset == '0 && out_res_r.payload_length == '0)
    else $error("failed result carries payload offset or length");

  a_ovf_first: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_snap_r.ovf |-> s2_fail_r && s2_st_r == ST_TOO_LONG)
    else $error("overflow not given top priority");

endmodule

### hdl/rtp_header_parser.sv
// RTP fixed-header parser, top level.
// Instantiates rtph_capture and rtph_eval; depends on rtph_pkg.
//
// Input: one packet byte per beat on in_tdata[7:0], in_tlast on the final
// byte of the packet. Output: one result beat per packet, after its last
// byte, carrying the header fields, payload offset/length and a status.
// Throughput: one byte per cycle sustained; in_tready stays high while the
// result path has room, including while a finished result waits.
// After the edge that accepts the last byte, the result passes the snapshot
// register, the header-length register and the result register to out_tvalid.
// Reset (rst_n low, synchronous) clears the byte counter, captured header
// words and all valid flags; no packet is in flight afterwards.
// If the receiver stalls, the result is held; the two internal stages
// keep filling, then in_tready drops until out_tready frees a slot.
// Lengths above 2^COUNT_BITS-1 bytes saturate the counter and report the
// too-long status.
module rtp_header_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] data_byte
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [2:0] status, [4:3] version, [5] has_padding, [6] has_extension,
  // [10:7] csrc_count, [11] marker, [18:12] payload_type,
  // [34:19] sequence_res, [66:35] time_stamp, [98:67] source_id,
  // [114:99] payload_offset, [130:115] payload_length, [135:131] zero
  output logic [rtph_pkg::OUT_W-1:0] out_tdata
);
  import rtph_pkg::*;

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  rtph_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  rtph_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### tb/sv/rtp_header_parser_test.sv
`timescale 1ns / 100ps
// Testbench for rtp_header_parser: streams RTP packets byte by byte and checks
// every result beat against a header predictor held in a small scoreboard class.
// Depends on rtph_pkg and the rtp_header_parser RTL.

module rtp_header_parser_test;
  import rtph_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  class header_board;
    logic [CNT_W-1:0] count;
    logic [7:0]       flags;
    logic [7:0]       mtype;
    logic [15:0]      seq;
    logic [31:0]      stamp;
    logic [31:0]      source;
    logic [15:0]      ext_len;
    logic             saturated;
    res_t             expected_headers[$];
    int               errors;

    function void clear();
      count = '0;
      flags = '0;
      mtype = '0;
      seq = '0;
      stamp = '0;
      source = '0;
      ext_len = '0;
      saturated = 1'b0;
    endfunction

    // Accepted input beat: update the captured header and, on the last byte,
    // queue the header result that the packet must produce.
    function void take_byte(logic [7:0] b, logic is_last);
      int unsigned idx, hl, size, hdr, plen;
      logic [2:0] st;
      res_t e;
      idx = count;
      hl = HDR_FIXED + 4 * flags[3:0];
      if (idx == 0) flags = b;
      else if (idx == 1) mtype = b;
      else if (idx < 4) seq = {seq[7:0], b};
      else if (idx < 8) stamp = {stamp[23:0], b};
      else if (idx < 12) source = {source[23:0], b};
      else if (idx == hl + 2 || idx == hl + 3) ext_len = {ext_len[7:0], b};
      if (count == CNT_MAX) saturated = 1'b1;
      else count = count + 1'b1;
      if (!is_last) return;

      size = count;
      hdr = HDR_FIXED + 4 * flags[3:0];
      plen = 0;
      st = ST_OK;
      if (saturated) st = ST_TOO_LONG;
      else if (size < HDR_FIXED) st = ST_UNDER_12;
      else if (flags[4] && size < hdr + 4) st = ST_NO_EXT;
      else begin
        if (flags[4]) hdr = hdr + 4 + 4 * ext_len;
        if (size < hdr) st = ST_SHORT_HDR;
        else begin
          plen = size - hdr;
          // padding count is ignored when nothing follows the header
          if (flags[5] && plen > 0) begin
            if (b <= plen) plen = plen - b;
            else st = ST_BAD_PAD;
          end
        end
      end
      if (st != ST_OK) begin
        hdr = 0;
        plen = 0;
      end
      e.status = st;
      e.version = flags[7:6];
      e.has_padding = flags[5];
      e.has_extension = flags[4];
      e.csrc_count = flags[3:0];
      e.marker = mtype[7];
      e.payload_type = mtype[6:0];
      e.sequence_res = seq;
      e.time_stamp = stamp;
      e.source_id = source;
      e.payload_offset = hdr[15:0];
      e.payload_length = plen[15:0];
      expected_headers.push_back(e);
      clear();
    endfunction

    function void cmp_field(string nm, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, exp_v, got_v);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_headers.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        return;
      end
      e = expected_headers.pop_front();
      cmp_field("status", e.status, got.status);
      cmp_field("version", e.version, got.version);
      cmp_field("has_padding", e.has_padding, got.has_padding);
      cmp_field("has_extension", e.has_extension, got.has_extension);
      cmp_field("csrc_count", e.csrc_count, got.csrc_count);
      cmp_field("marker", e.marker, got.marker);
      cmp_field("payload_type", e.payload_type, got.payload_type);
      cmp_field("sequence_res", e.sequence_res, got.sequence_res);
      cmp_field("time_stamp", e.time_stamp, got.time_stamp);
      cmp_field("source_id", e.source_id, got.source_id);
      cmp_field("payload_offset", e.payload_offset, got.payload_offset);
      cmp_field("payload_length", e.payload_length, got.payload_length);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic             no_idle = 1'b0;
  logic             hold_tog = 1'b0;
  logic             hold_seen = 1'b0;
  int               hold_left = 0;
  int               bytes_sent = 0;
  header_board      board;

  rtp_header_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.take_byte(in_tdata, in_tlast);
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(res_t'(out_tdata[RES_W-1:0]));
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= 150;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic is_last);
    if (!no_idle) begin
      while ($urandom_range(99) < 22) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= is_last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_packet(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    bytes_sent += q.size();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.expected_headers.size() != 0);
  endtask

  function automatic byte_q_t filled(int n, logic [7:0] b0, logic [7:0] rest);
    byte_q_t q;
    q.push_back(b0);
    repeat (n - 1) q.push_back(rest);
    return q;
  endfunction

  // Mostly version 2 headers with random CSRC list, extension and padding.
  function automatic byte_q_t good_packet();
    byte_q_t q;
    logic [7:0] b0;
    logic [15:0] words;
    int cc, n, pad;
    cc = ($urandom_range(99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    b0 = {($urandom_range(99) < 90) ? 2'd2 : 2'($urandom_range(0, 3)),
          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 4'(cc)};
    q.push_back(b0);
    repeat (11 + 4 * cc) q.push_back(8'($urandom));
    if (b0[4]) begin
      words = ($urandom_range(99) < 95) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      q.push_back(8'($urandom));
      q.push_back(8'($urandom));
      q.push_back(words[15:8]);
      q.push_back(words[7:0]);
      if (words < 4) repeat (4 * words) q.push_back(8'($urandom));
    end
    n = $urandom_range(0, 40);
    if (b0[5] && n > 0) begin
      pad = ($urandom_range(99) < 85) ? $urandom_range(0, n) : $urandom_range(n + 1, 255);
      repeat (n - 1) q.push_back(8'($urandom));
      q.push_back(8'(pad));
    end else begin
      repeat (n) q.push_back(8'($urandom));
    end
    return q;
  endfunction

  function automatic byte_q_t noise_packet();
    byte_q_t q;
    repeat ($urandom_range(1, 30)) q.push_back(8'($urandom));
    return q;
  endfunction

  initial begin
    #10_000_000;
    $display("rtp_header_parser_test NOT OK");
    $finish;
  end

  initial begin
    byte_q_t q;
    int cut, pkts;
    board = new();
    board.clear();
    board.errors = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed packets
    send_packet(filled(1, 8'hFF, 8'h00));
    send_packet(filled(11, 8'hFF, 8'hFF));
    send_packet(filled(12, 8'h00, 8'h00));
    send_packet(filled(12, 8'h80, 8'hFF));
    send_packet(filled(14, 8'h90, 8'hFF));       // extension bit, no room for its header
    q = filled(20, 8'h90, 8'h00);
    q[15] = 8'h02;                               // two extension words do not fit
    send_packet(q);
    send_packet(filled(30, 8'h8F, 8'h55));       // 15 CSRC words, packet too short
    q = filled(20, 8'hA0, 8'h11);
    q[19] = 8'h20;                               // pad count beyond payload
    send_packet(q);
    send_packet(filled(12, 8'hA0, 8'hFF));       // padding bit with empty payload
    q = filled(20, 8'h80, 8'h00);
    q[14] = 8'hAB;                               // extension word without extension bit
    q[15] = 8'hCD;
    send_packet(q);
    q = filled(32, 8'hB1, 8'h3C);
    q[18] = 8'h00;
    q[19] = 8'h01;
    q[31] = 8'h08;                               // padding eats the whole payload
    send_packet(q);
    send_packet(filled(25, 8'hA0, 8'h00));       // zero pad count
    q = filled(13, 8'hA0, 8'h01);
    send_packet(q);
    send_packet(filled(80, 8'h9F, 8'h00));       // full CSRC list plus extension
    send_packet(filled(100, 8'hFF, 8'hFF));      // all ones, huge extension length
    wait_drained();

    // long receiver hold-off while minimum packets keep coming
    no_idle <= 1'b1;
    hold_tog <= ~hold_tog;
    repeat (8) send_packet(filled(12, 8'h80, 8'($urandom)));
    no_idle <= 1'b0;
    wait_drained();

    // random packets
    pkts = 0;
    while (bytes_sent < 900) begin
      if (pkts == 1) no_idle <= 1'b1;
      if (pkts == 4) no_idle <= 1'b0;
      cut = $urandom_range(99);
      if (cut < 70) q = good_packet();
      else if (cut < 85) begin
        q = good_packet();
        cut = $urandom_range(1, q.size());
        while (q.size() > cut) void'(q.pop_back());
      end else q = noise_packet();
      send_packet(q);
      pkts++;
      if ($urandom_range(99) < 5) wait_drained();
    end
    no_idle <= 1'b0;
    wait_drained();

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.expected_headers.size() == 0) begin
      $display("rtp_header_parser_test OK");
    end else begin
      $display("rtp_header_parser_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hdl/rtph_pkg.sv
hdl/rtph_capture.sv
hdl/rtph_eval.sv
hdl/rtp_header_parser.sv
tb/sv/rtp_header_parser_test.sv
